// ----- sv/fbcs_pkg.sv -----
// Shared types, status codes and the blink color table for the fault blink
// code sequencer. No dependencies.
`default_nettype none
package fbcs_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FATAL     = 3'd1;
  localparam logic [2:0] ST_NET_DOWN  = 3'd2;
  localparam logic [2:0] ST_WIFI_DOWN = 3'd3;
  localparam logic [2:0] ST_MQTT_DOWN = 3'd4;
  localparam logic [2:0] ST_OTA_FAIL  = 3'd5;

  localparam logic [1:0] REG_ON_TICKS  = 2'd0;
  localparam logic [1:0] REG_OFF_TICKS = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS = 2'd2;

  localparam logic [23:0] COLOR_DARK    = 24'h000000;
  localparam logic [23:0] COLOR_RED     = 24'h280000;
  localparam logic [23:0] COLOR_AMBER   = 24'h280E00;
  localparam logic [23:0] COLOR_BLUE    = 24'h000028;
  localparam logic [23:0] COLOR_MAGENTA = 24'h280028;

  typedef enum logic [2:0] {
    PH_ON  = 3'b001,
    PH_OFF = 3'b010,
    PH_GAP = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0] on_ticks;
    logic [3:0] off_ticks;
    logic [3:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cur_status;
    logic [2:0]  owner;
    logic [2:0]  blinks_done;
    phase_t      phase;
    logic [3:0]  tick_cnt;
    logic [23:0] color;
  } seq_state_t;

  function automatic logic [23:0] code_color(input logic [2:0] code);
    logic [23:0] c;
    case (code)
      ST_FATAL:     c = COLOR_RED;
      ST_NET_DOWN:  c = COLOR_RED;
      ST_WIFI_DOWN: c = COLOR_AMBER;
      ST_MQTT_DOWN: c = COLOR_BLUE;
      ST_OTA_FAIL:  c = COLOR_MAGENTA;
      default:      c = COLOR_DARK;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/fbcs_step.sv -----
// Next-state logic of the blink sequencer for one set event or one tick.
// Depends on fbcs_pkg.
`default_nettype none
module fbcs_step import fbcs_pkg::*; (
  input  wire cfg_t       cfg,
  input  wire seq_state_t st,
  input  wire logic       mode,
  input  wire logic [2:0] status_code,
  output seq_state_t      st_nxt,
  output logic            ignored
);

  logic [3:0] cnt_inc;
  logic [3:0] len;
  logic [2:0] blinks_inc;
  logic       owner_change;

  always_comb begin
    st_nxt       = st;
    ignored      = 1'b0;
    owner_change = (st.owner != st.cur_status);
    len          = 4'd1;
    cnt_inc      = 4'd0;
    blinks_inc   = 3'd0;

    if (mode) begin
      if (st.cur_status == ST_FATAL) begin
        ignored = 1'b1;
      end else begin
        st_nxt.cur_status = (status_code > ST_OTA_FAIL) ? ST_OK : status_code;
      end
    end else begin
      // A status change drops the running pattern and restarts it.
      st_nxt.owner = st.cur_status;
      if (owner_change) begin
        st_nxt.blinks_done = 3'd0;
        st_nxt.phase       = PH_ON;
        st_nxt.tick_cnt    = 4'd0;
      end
      if (st_nxt.owner == ST_OK || st_nxt.owner == ST_FATAL) begin
        st_nxt.color       = code_color(st_nxt.owner);
        st_nxt.blinks_done = 3'd0;
        st_nxt.phase       = PH_ON;
        st_nxt.tick_cnt    = 4'd0;
      end else begin
        case (st_nxt.phase)
          PH_ON:   len = cfg.on_ticks;
          PH_OFF:  len = cfg.off_ticks;
          PH_GAP:  len = cfg.gap_ticks;
          default: len = 4'd1;
        endcase
        if (len == 4'd0) begin
          len = 4'd1;
        end
        cnt_inc    = st_nxt.tick_cnt + 4'd1;
        blinks_inc = st_nxt.blinks_done + 3'd1;
        st_nxt.tick_cnt = cnt_inc;
        if (cnt_inc >= len) begin
          st_nxt.tick_cnt = 4'd0;
        end
        case (st_nxt.phase)
          PH_ON: begin
            st_nxt.color = code_color(st_nxt.owner);
            if (cnt_inc >= len) begin
              st_nxt.phase = PH_OFF;
            end
          end
          PH_OFF: begin
            st_nxt.color = COLOR_DARK;
            if (cnt_inc >= len) begin
              if (blinks_inc >= st_nxt.owner) begin
                st_nxt.blinks_done = 3'd0;
                st_nxt.phase       = PH_GAP;
              end else begin
                st_nxt.blinks_done = blinks_inc;
                st_nxt.phase       = PH_ON;
              end
            end
          end
          PH_GAP: begin
            st_nxt.color = COLOR_DARK;
            if (cnt_inc >= len) begin
              st_nxt.phase = PH_ON;
            end
          end
          default: begin
            st_nxt.color    = COLOR_DARK;
            st_nxt.tick_cnt = 4'd0;
            st_nxt.phase    = PH_ON;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/fault_blink_code_sequencer_top.sv -----
// Top level of the fault blink code sequencer: stream ports, register file,
// sequencer state and result register. Depends on fbcs_pkg and fbcs_step.
`default_nettype none
//
//  channel | direction | transfer carries
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tuser: mode; tdata: status_code
//  out_    | master    | tdata: red, green, blue, held_status, set_ignored
//  cfg_    | write     | on_ticks (0), off_ticks (1), gap_ticks (2)
//
// On every input transfer the step logic updates the sequencer state and
// loads the result register at the same edge, so one item per clock is
// accepted whenever the result register is empty or is being drained in that
// cycle. Only the result register can stall the input.
// Reset (rst_n low, synchronous) restores the default tick counts, status ok,
// a dark LED, and empties the result register.
module fault_blink_code_sequencer_top import fbcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] status_code, [7:3] zero
  input  wire logic [0:0]  in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] red_level, [15:8] green_level,
                                       // [23:16] blue_level, [26:24] held_status,
                                       // [27] set_ignored, [31:28] zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  cfg_t        cfg_r;
  seq_state_t  st_r;
  seq_state_t  st_nxt;
  logic        ignored;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] out_data_nxt;
  logic        in_xfer;

  // The result register is the only buffer; it frees up in the cycle it is
  // taken, so back-to-back transfers flow at full rate while out_tready stays high.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  fbcs_step u_step (
    .cfg         (cfg_r),
    .st          (st_r),
    .mode        (in_tuser[0]),
    .status_code (in_tdata[2:0]),
    .st_nxt      (st_nxt),
    .ignored     (ignored)
  );

  assign out_data_nxt = {4'd0, ignored, st_nxt.cur_status,
                         st_nxt.color[7:0], st_nxt.color[15:8], st_nxt.color[23:16]};

  // Register file. Writes must come only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_ticks  <= 4'd2;
      cfg_r.off_ticks <= 4'd2;
      cfg_r.gap_ticks <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_TICKS:  cfg_r.on_ticks  <= cfg_wdata;
        REG_OFF_TICKS: cfg_r.off_ticks <= cfg_wdata;
        REG_GAP_TICKS: cfg_r.gap_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur_status  <= ST_OK;
      st_r.owner       <= ST_OK;
      st_r.blinks_done <= 3'd0;
      st_r.phase       <= PH_ON;
      st_r.tick_cnt    <= 4'd0;
      st_r.color       <= COLOR_DARK;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- tb/blink_code_checker.sv -----
// Scoreboard for the fault blink code sequencer: a small shared package of
// testbench codes and a checker that predicts every LED result and compares.
// Depends on fbcs_pkg for status codes, register indexes and colors.
`default_nettype none
package fbcs_tb_pkg;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SET  = 1'b1
  } item_mode_e;

  // Index 3 is not a register; writes to it must leave everything alone.
  localparam logic [1:0] REG_SPARE = 2'd3;

endpackage

module blink_code_checker import fbcs_pkg::*, fbcs_tb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] status_code, [7:3] zero
  input  wire logic [0:0]  in_tuser,   // [0] mode
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                       // [26:24] held_status, [27] set_ignored
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata,
  output int               mismatch_count,
  output int               leds_pending
);

  typedef enum logic [1:0] {
    STEP_ON    = 2'd0,
    STEP_OFF   = 2'd1,
    STEP_GAP   = 2'd2,
    STEP_SPARE = 2'd3
  } blink_step_e;

  // Declared from the top bit down so that a cast of out_tdata[27:0] lines up.
  typedef struct packed {
    logic       ignored;
    logic [2:0] held;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_result_t;

  logic [3:0]  on_len, off_len, gap_len;
  logic [2:0]  held_status, pattern_status, blinks_shown;
  blink_step_e step;
  logic [3:0]  step_ticks;
  logic [23:0] led_drive;
  led_result_t expected_leds[$];

  initial mismatch_count = 0;
  initial leds_pending = 0;

  function automatic logic [3:0] ticks_of(input logic [3:0] len);
    return (len == 4'd0) ? 4'd1 : len;
  endfunction

  // Counts one tick of the current step and tells whether the step is over.
  function automatic bit step_finished(input logic [3:0] len);
    step_ticks = step_ticks + 4'd1;
    if (step_ticks >= ticks_of(len)) begin
      step_ticks = 4'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_model();
    on_len = 4'd2;
    off_len = 4'd2;
    gap_len = 4'd8;
    held_status = ST_OK;
    pattern_status = ST_OK;
    blinks_shown = 3'd0;
    step = STEP_ON;
    step_ticks = 4'd0;
    led_drive = COLOR_DARK;
  endtask

  task automatic advance_pattern();
    if (pattern_status != held_status) begin
      pattern_status = held_status;
      blinks_shown = 3'd0;
      step = STEP_ON;
      step_ticks = 4'd0;
    end
    if (pattern_status == ST_OK || pattern_status == ST_FATAL ||
        pattern_status > ST_OTA_FAIL) begin
      led_drive = (pattern_status == ST_FATAL) ? COLOR_RED : COLOR_DARK;
      blinks_shown = 3'd0;
      step = STEP_ON;
      step_ticks = 4'd0;
    end else begin
      case (step)
        STEP_ON: begin
          case (pattern_status)
            ST_NET_DOWN:  led_drive = COLOR_RED;
            ST_WIFI_DOWN: led_drive = COLOR_AMBER;
            ST_MQTT_DOWN: led_drive = COLOR_BLUE;
            default:      led_drive = COLOR_MAGENTA;
          endcase
          if (step_finished(on_len)) step = STEP_OFF;
        end
        STEP_OFF: begin
          led_drive = COLOR_DARK;
          if (step_finished(off_len)) begin
            blinks_shown = blinks_shown + 3'd1;
            if (blinks_shown >= pattern_status) begin
              blinks_shown = 3'd0;
              step = STEP_GAP;
            end else begin
              step = STEP_ON;
            end
          end
        end
        STEP_GAP: begin
          led_drive = COLOR_DARK;
          if (step_finished(gap_len)) step = STEP_ON;
        end
        default: begin
          led_drive = COLOR_DARK;
          step_ticks = 4'd0;
          step = STEP_ON;
        end
      endcase
    end
  endtask

  task automatic predict_led(input logic mode, input logic [2:0] code,
                             output led_result_t res);
    res.ignored = 1'b0;
    if (mode == MODE_SET) begin
      if (held_status == ST_FATAL) res.ignored = 1'b1;
      else held_status = (code > ST_OTA_FAIL) ? ST_OK : code;
    end else begin
      advance_pattern();
    end
    res.red = led_drive[23:16];
    res.green = led_drive[15:8];
    res.blue = led_drive[7:0];
    res.held = held_status;
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatch_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  always @(posedge clk) begin : watch
    led_result_t seen, want;
    if (!rst_n) begin
      clear_model();
      expected_leds.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = led_result_t'(out_tdata[27:0]);
        if (expected_leds.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_tdata), 0);
        end else begin
          want = expected_leds.pop_front();
          if (seen.red != want.red)
            report_mismatch("red_level", int'(seen.red), int'(want.red));
          if (seen.green != want.green)
            report_mismatch("green_level", int'(seen.green), int'(want.green));
          if (seen.blue != want.blue)
            report_mismatch("blue_level", int'(seen.blue), int'(want.blue));
          if (seen.held != want.held)
            report_mismatch("held_status", int'(seen.held), int'(want.held));
          if (seen.ignored != want.ignored)
            report_mismatch("set_ignored", int'(seen.ignored), int'(want.ignored));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_led(in_tuser[0], in_tdata[2:0], want);
        expected_leds.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ON_TICKS:  on_len = cfg_wdata;
          REG_OFF_TICKS: off_len = cfg_wdata;
          REG_GAP_TICKS: gap_len = cfg_wdata;
          default: ;
        endcase
      end
    end
    leds_pending = expected_leds.size();
  end

endmodule
`default_nettype wire

// ----- tb/fault_blink_code_sequencer_top_test.sv -----
// Top of the fault blink code sequencer testbench: clock, reset, stimulus,
// register writes and the verdict. Depends on fbcs_pkg, fbcs_tb_pkg,
// blink_code_checker and the block itself.
`default_nettype none
module fault_blink_code_sequencer_top_test;
  import fbcs_pkg::*;
  import fbcs_tb_pkg::*;

  localparam int PERIOD = 12;
  localparam int RESET_CYCLES = 11;
  // The slowest correct run is about 1850 transfers when both sides stall
  // their longest; this limit is many times as long as that run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 229;
  localparam int FATAL_AT = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_wdata;
  int          mismatch_count, leds_pending;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;

  always #(PERIOD / 2) clk = ~clk;

  fault_blink_code_sequencer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  blink_code_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .leds_pending   (leds_pending)
  );

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. The receiver alternates ready stretches of random length with
  // stall bursts, unless idling is off. All inputs change only on the falling
  // edge, so the block and the checker see settled values at the rising edge.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        out_tready = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready = 1'b0;
        hold = $urandom_range(1, 6) - 1;
      end else begin
        out_tready = 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  // Offers one item and returns on the falling edge after its transfer. Valid
  // stays high when the next item follows at once, and drops only for a gap.
  task automatic send_item(input item_mode_e mode, input logic [2:0] code);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = {5'b00000, code};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [3:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Lets every outstanding result come back, then waits DRAIN_CYCLES more, so
  // that register writes only ever land on an idle block.
  task automatic drain();
    in_tvalid = 1'b0;
    while (leds_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase_no, n;
    bit fatal_held;
    logic [2:0] code;
    logic [3:0] on_v, off_v, gap_v;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = MODE_TICK;
    cfg_we = 1'b0;
    cfg_index = REG_ON_TICKS;
    cfg_wdata = 4'd0;
    fatal_held = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, run with the reset tick counts. It starts with a tick on
    // status ok, stores the two unknown codes (they must read back as ok),
    // starts net down and lets it blink, then switches status in the middle
    // of a pattern so that the running pattern is dropped at the next tick.
    // Two sets in a row check that only the last one counts, and a set always
    // repeats the present drive. Fatal latches until reset, and reset comes
    // only once, so it is saved for the final phase.
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, 3'd6);
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, 3'd7);
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_NET_DOWN);
    repeat (3) send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_WIFI_DOWN);
    repeat (2) send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_MQTT_DOWN);
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_OTA_FAIL);
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_OK);
    send_item(MODE_TICK, ST_OK);
    send_item(MODE_SET, ST_OTA_FAIL);
    send_item(MODE_SET, ST_NET_DOWN);
    repeat (2) send_item(MODE_TICK, ST_OK);
    drain();

    // Random phases. Each starts from an idle block with new tick counts: the
    // largest first, then the smallest so that steps are cut short while
    // their count already passes the new length, then zero (taken as one),
    // then mostly small random counts. Most items are ticks so that the
    // blink groups run through; sets are sparse and restart the pattern.
    for (phase_no = 1; phase_no <= PHASES; phase_no++) begin
      case (phase_no)
        1: begin
          on_v = 4'd15; off_v = 4'd15; gap_v = 4'd15;
        end
        2: begin
          on_v = 4'd1; off_v = 4'd1; gap_v = 4'd1;
        end
        3: begin
          on_v = 4'd0; off_v = 4'd0; gap_v = 4'd0;
        end
        default: begin
          on_v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 4));
          off_v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 4));
          gap_v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 6));
        end
      endcase
      write_reg(REG_ON_TICKS, on_v);
      write_reg(REG_OFF_TICKS, off_v);
      write_reg(REG_GAP_TICKS, gap_v);
      // The spare index must not disturb any register.
      if (phase_no == 3 || phase_no == 6) write_reg(REG_SPARE, 4'($urandom_range(0, 15)));

      // One middle phase and the final phase run without any idling.
      idle_on = (phase_no != 5 && phase_no != PHASES);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase_no == PHASES && n == FATAL_AT) begin
          // From here on every set must be refused and the LED stays red.
          send_item(MODE_SET, ST_FATAL);
          fatal_held = 1'b1;
        end else if ($urandom_range(0, 99) < (fatal_held ? 12 : 4)) begin
          code = 3'($urandom_range(0, 7));
          if (!fatal_held && code == ST_FATAL) code = ST_NET_DOWN;
          send_item(MODE_SET, code);
        end else begin
          send_item(MODE_TICK, 3'($urandom_range(0, 7)));
        end
      end
      drain();
    end

    in_tvalid = 1'b0;
    while (leds_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/fbcs_pkg.sv
sv/fbcs_step.sv
sv/fault_blink_code_sequencer_top.sv
tb/blink_code_checker.sv
tb/fault_blink_code_sequencer_top_test.sv
